>>> src/olie_pkg.sv
// ----------------------------------------------------------------------------
// olie_pkg
// Shared types and constants for the ordered list insert/extract unit.
// ----------------------------------------------------------------------------
package olie_pkg;

    localparam int OLIE_DEPTH_DEFAULT = 64;

    localparam int OP_W    = 4;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 16;
    localparam int CAP_W   = 7;
    localparam int LEN_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 4'd0,
        OP_INS_LAST  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_EXT_FIRST = 4'd3,
        OP_EXT_LAST  = 4'd4,
        OP_EXT_AT    = 4'd5,
        OP_RD_FIRST  = 4'd6,
        OP_RD_LAST   = 4'd7,
        OP_RD_AT     = 4'd8,
        OP_CLEAR     = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_COUNT,
        POS_LAST,
        POS_REQ
    } pos_src_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic       load_req;
        pos_src_t   pos_src;
        logic       ins_en;
        logic       ext_en;
        logic       clr_en;
        logic       take_entry;
        logic       res_load;
        status_t    res_status;
    } olie_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            null_val;
        logic            pos_gt_count;
        logic            pos_ge_count;
    } olie_flags_t;

endpackage

>>> src/olie_datapath.sv
// ----------------------------------------------------------------------------
// olie_datapath
// Entry shift array, length and capacity registers, request and result
// registers.
// ----------------------------------------------------------------------------
module olie_datapath #(
    parameter int DEPTH = olie_pkg::OLIE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [olie_pkg::CAP_W-1:0]    cfg_data,
    input  logic [olie_pkg::OP_W-1:0]     op,
    input  logic [olie_pkg::POS_W-1:0]    position,
    input  logic [olie_pkg::VALUE_W-1:0]  value,
    input  logic [olie_pkg::SIZE_W-1:0]   size_bytes,
    input  olie_pkg::olie_cmd_t           cmd,
    output olie_pkg::olie_flags_t         flags,
    output logic [1:0]                    status,
    output logic [olie_pkg::VALUE_W-1:0]  out_value,
    output logic [olie_pkg::SIZE_W-1:0]   out_size,
    output logic [olie_pkg::LEN_W-1:0]    length,
    output logic                          full_res,
    output logic                          empty_res
);
    import olie_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CAP_W-1:0]   cap_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic [OP_W-1:0]    op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [SIZE_W-1:0]  size_reg;

    logic [VALUE_W-1:0] ent_val_reg [DEPTH];
    logic [SIZE_W-1:0]  ent_size_reg [DEPTH];

    logic [1:0]         res_status_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic [SIZE_W-1:0]  res_size_reg;
    logic [LEN_W-1:0]   res_len_reg;
    logic               res_full_reg;
    logic               res_empty_reg;

    logic [CMPW-1:0]    cap_ext;
    logic [CMPW-1:0]    eff_cap;
    logic [CMPW-1:0]    count_ext;
    logic [CMPW-1:0]    count_next_ext;
    logic [CMPW-1:0]    pos_sel;
    logic [IW-1:0]      pos_idx;

    always_comb
    begin
        cap_ext   = CMPW'(cap_reg);
        eff_cap   = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
        count_ext = CMPW'(count_reg);
        case (cmd.pos_src)
            POS_ZERO:  pos_sel = '0;
            POS_COUNT: pos_sel = count_ext;
            POS_LAST:  pos_sel = (count_ext == '0) ? '0 : count_ext - CMPW'(1);
            default:   pos_sel = CMPW'(pos_reg);
        endcase
        pos_idx = pos_sel[IW-1:0];

        flags.op           = op_reg;
        flags.full         = (count_ext >= eff_cap);
        flags.null_val     = (value_reg == '0);
        flags.pos_gt_count = (pos_sel > count_ext);
        flags.pos_ge_count = (pos_sel >= count_ext);

        count_next = count_reg;
        if (cmd.clr_en)
        begin
            count_next = '0;
        end
        else if (cmd.ins_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.ext_en)
        begin
            count_next = count_reg - CW'(1);
        end
        count_next_ext = CMPW'(count_next);
    end

    // entry shift array
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_ent
        logic [VALUE_W-1:0] val_next;
        logic [SIZE_W-1:0]  size_next;
        logic               wr;

        always_comb
        begin
            wr        = 1'b0;
            val_next  = ent_val_reg[g];
            size_next = ent_size_reg[g];
            if (cmd.ins_en)
            begin
                if (CMPW'(g) == pos_sel)
                begin
                    wr        = 1'b1;
                    val_next  = value_reg;
                    size_next = size_reg;
                end
                else if (CMPW'(g) > pos_sel)
                begin
                    wr = 1'b1;
                    if (g > 0)
                    begin
                        val_next  = ent_val_reg[(g > 0) ? g - 1 : 0];
                        size_next = ent_size_reg[(g > 0) ? g - 1 : 0];
                    end
                end
            end
            else if (cmd.ext_en && (CMPW'(g) >= pos_sel) && (g < DEPTH - 1))
            begin
                wr        = 1'b1;
                val_next  = ent_val_reg[(g < DEPTH - 1) ? g + 1 : g];
                size_next = ent_size_reg[(g < DEPTH - 1) ? g + 1 : g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr)
            begin
                ent_val_reg[g]  <= val_next;
                ent_size_reg[g] <= size_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= op;
            pos_reg   <= position;
            value_reg <= value;
            size_reg  <= size_bytes;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.take_entry ? ent_val_reg[pos_idx] : '0;
            res_size_reg   <= cmd.take_entry ? ent_size_reg[pos_idx] : '0;
            res_len_reg    <= LEN_W'(count_next);
            res_full_reg   <= (count_next_ext >= eff_cap);
            res_empty_reg  <= (count_next == '0);
        end
    end

    assign status    = res_status_reg;
    assign out_value = res_value_reg;
    assign out_size  = res_size_reg;
    assign length    = res_len_reg;
    assign full_res  = res_full_reg;
    assign empty_res = res_empty_reg;

endmodule

>>> src/olie_ctrl.sv
// ----------------------------------------------------------------------------
// olie_ctrl
// Request sequencing, op decode and check ordering for the list datapath.
// ----------------------------------------------------------------------------
module olie_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  olie_pkg::olie_flags_t flags,
    output olie_pkg::olie_cmd_t   cmd
);
    import olie_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        go;

    assign go = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.pos_src    = POS_REQ;
        cmd.res_status = ST_OK;
        cmd.load_req   = (state_reg == S_IDLE) && in_valid;
        cmd.res_load   = go;
        in_stall       = (state_reg != S_IDLE);
        out_valid      = out_valid_reg;

        unique case (flags.op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT:
            begin
                if (flags.op == OP_INS_FIRST)
                begin
                    cmd.pos_src = POS_ZERO;
                end
                else if (flags.op == OP_INS_LAST)
                begin
                    cmd.pos_src = POS_COUNT;
                end
                if (flags.full)
                begin
                    cmd.res_status = ST_FULL;
                end
                else if (flags.null_val)
                begin
                    cmd.res_status = ST_NULL;
                end
                else if (flags.pos_gt_count)
                begin
                    cmd.res_status = ST_RANGE;
                end
                else
                begin
                    cmd.ins_en = go;
                end
            end
            OP_EXT_FIRST, OP_EXT_LAST, OP_EXT_AT,
            OP_RD_FIRST, OP_RD_LAST, OP_RD_AT:
            begin
                if (flags.op == OP_EXT_FIRST || flags.op == OP_RD_FIRST)
                begin
                    cmd.pos_src = POS_ZERO;
                end
                else if (flags.op == OP_EXT_LAST || flags.op == OP_RD_LAST)
                begin
                    cmd.pos_src = POS_LAST;
                end
                if (flags.pos_ge_count)
                begin
                    cmd.res_status = ST_RANGE;
                end
                else
                begin
                    cmd.take_entry = 1'b1;
                    cmd.ext_en     = go && (flags.op == OP_EXT_FIRST ||
                                            flags.op == OP_EXT_LAST ||
                                            flags.op == OP_EXT_AT);
                end
            end
            OP_CLEAR:
            begin
                cmd.clr_en = go;
            end
            default:
            begin
                cmd.res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/ordered_list_insert_extract_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_extract_unit
// Densely packed ordered list of handle/size entries with insert, extract,
// read at the first, last or a given position, and clear of the whole list.
//
// Input channel: in_valid/in_stall with op, position, value, size_bytes.
// Output channel: out_valid/out_stall with status, out_value, out_size,
// length, full_res, empty_res; one result per request, in order.
// Configuration: cfg_we writes cfg_data into the capacity limit; write only
// while no request is outstanding.
// A request is captured, then executes in the execute state; its result is
// registered into the output register. Requests are not overlapped: the
// entry array shifts during the execute step of the controller, and the
// input stalls while a request is executing.
// When the receiver stalls, the result is held in the output register; the
// next request may be accepted, but it waits in execute until that result
// is taken.
// Reset: the length count clears to zero, capacity limit returns to 64, no result is
// pending. Entry storage is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_insert_extract_unit #(
    parameter int DEPTH = olie_pkg::OLIE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [olie_pkg::CAP_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [olie_pkg::OP_W-1:0]     op,
    input  logic [olie_pkg::POS_W-1:0]    position,
    input  logic [olie_pkg::VALUE_W-1:0]  value,
    input  logic [olie_pkg::SIZE_W-1:0]   size_bytes,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [olie_pkg::VALUE_W-1:0]  out_value,
    output logic [olie_pkg::SIZE_W-1:0]   out_size,
    output logic [olie_pkg::LEN_W-1:0]    length,
    output logic                          full_res,
    output logic                          empty_res
);
    import olie_pkg::*;

    olie_cmd_t   cmd;
    olie_flags_t flags;

    olie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    olie_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .op         (op),
        .position   (position),
        .value      (value),
        .size_bytes (size_bytes),
        .cmd        (cmd),
        .flags      (flags),
        .status     (status),
        .out_value  (out_value),
        .out_size   (out_size),
        .length     (length),
        .full_res   (full_res),
        .empty_res  (empty_res)
    );

endmodule
